@@ src/tsf_pkg.sv @@
package tsf_pkg;

   localparam int COORD_BITS = 8;
   localparam int FRAC_BITS  = 16;
   localparam int LEVEL_BITS = 8;
   // slope magnitude before sign: |dx| placed above the fraction
   localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;
   localparam int STEP_BITS  = 4;
   localparam int DIV_STAGES = (QUO_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int SLOPE_BITS = QUO_BITS + 1;
   localparam int OFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS  = OFF_BITS + SLOPE_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int NUM_EDGES  = 3;

   // edge numbering
   localparam int EDGE_AB = 0;
   localparam int EDGE_AC = 1;
   localparam int EDGE_BC = 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [SLOPE_BITS-1:0] slope_type;
   typedef logic signed [OFF_BITS-1:0] off_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;

   typedef struct packed {
      coord_type             ax;
      coord_type             ay;
      coord_type             bx;
      coord_type             by_coord;
      coord_type             cx;
      coord_type             cy;
      coord_type             row;
      logic [LEVEL_BITS-1:0] fill_level;
   } req_type;

   typedef struct packed {
      coord_type             span_row;
      coord_type             span_start;
      coord_type             span_end;
      logic [LEVEL_BITS-1:0] span_level;
      logic                  last_span;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vtx_type;

   typedef struct packed {
      vtx_type               a;
      vtx_type               b;
      vtx_type               c;
      coord_type             row;
      logic [LEVEL_BITS-1:0] lvl;
   } ctx_type;

   // long division state: divisor, partial remainder, dividend/quotient shifter
   typedef struct packed {
      coord_type             dsr;
      coord_type             rem;
      logic [QUO_BITS-1:0]   nq;
      logic                  neg;
   } div_type;

   function automatic div_type div_init(vtx_type p, vtx_type q);
      div_type   d;
      coord_type mag;
      d.neg = (q.x < p.x);
      mag   = d.neg ? coord_type'(p.x - q.x) : coord_type'(q.x - p.x);
      d.dsr = coord_type'(q.y - p.y);
      d.rem = '0;
      d.nq  = {mag, {FRAC_BITS{1'b0}}};
      return d;
   endfunction

   // STEP_BITS restoring steps, skipping those past the quotient width
   function automatic div_type div_step(div_type d, int base);
      div_type               t;
      logic [COORD_BITS:0]   r2;
      logic                  ge;
      t = d;
      for (int j = 0; j < STEP_BITS; j++) begin
         if (base + j < QUO_BITS) begin
            r2    = {t.rem, t.nq[QUO_BITS-1]};
            ge    = (r2 >= {1'b0, t.dsr});
            t.nq  = {t.nq[QUO_BITS-2:0], ge};
            t.rem = ge ? coord_type'(r2 - {1'b0, t.dsr}) : r2[COORD_BITS-1:0];
         end
      end
      return t;
   endfunction

   // signed slope, zero for a flat edge
   function automatic slope_type div_slope(div_type d);
      slope_type q;
      q = signed'({1'b0, d.nq});
      if (d.dsr == '0) begin
         return '0;
      end
      return d.neg ? slope_type'(-q) : q;
   endfunction

   // floor(x + offset * slope) clamped to the coordinate range
   function automatic coord_type edge_x(coord_type x, prod_type p);
      logic signed [SUM_BITS-1:0] sum;
      logic signed [SUM_BITS-1:0] fl;
      sum = $signed({{(SUM_BITS-QUO_BITS){1'b0}}, x, {FRAC_BITS{1'b0}}}) + SUM_BITS'(p);
      fl  = sum >>> FRAC_BITS;
      if (fl[SUM_BITS-1]) begin
         return '0;
      end
      if (|fl[SUM_BITS-2:COORD_BITS]) begin
         return '1;
      end
      return fl[COORD_BITS-1:0];
   endfunction

endpackage

@@ src/triangle_scanline_fill.sv @@
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_data (tsf_pkg::req_type)
// rsp     | out | rsp_valid/rsp_ready  | rsp_data (tsf_pkg::rsp_type)
//
// a word can enter each cycle while the pipe advances; it passes the sort register,
// DIV_STAGES slope divider stages at STEP_BITS quotient bits per stage, then the
// slope, multiply and output stages.
// a query on the middle vertex's row gives two words and holds the pipe while the upper one leaves.
// a stall at rsp freezes every stage at once; nothing is lost or repeated.
// synchronous reset clears the valid bits only.
module triangle_scanline_fill (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsf_pkg::rsp_type rsp_data
);

   localparam int NS = tsf_pkg::DIV_STAGES;
   localparam int NE = tsf_pkg::NUM_EDGES;

   logic advance;

   // sort stage and divider stages
   tsf_pkg::ctx_type ctx_in;
   tsf_pkg::ctx_type ctx_ff [0:NS];
   tsf_pkg::div_type div_ff [0:NS][0:NE-1];
   logic             vld_ff [0:NS];

   // slope stage
   tsf_pkg::ctx_type   sl_ctx_ff;
   tsf_pkg::slope_type sl_s_ff [0:NE-1];
   tsf_pkg::off_type   sl_offa_ff, sl_offb_ff;
   logic               sl_vld_ff, sl_up_ff, sl_lo_ff;

   // multiply stage
   tsf_pkg::ctx_type  mu_ctx_ff;
   tsf_pkg::prod_type mu_p_ff [0:NE-1];
   logic              mu_vld_ff, mu_up_ff, mu_lo_ff;

   // output stage
   tsf_pkg::rsp_type em_hi_ff, em_lw_ff;
   logic             em_up_ff, em_lo_ff;

   tsf_pkg::coord_type x_ab, x_ac, x_bc;

   // whole pipe moves when the output stage empties this cycle
   assign advance   = !(em_up_ff || em_lo_ff) || (rsp_ready && !(em_up_ff && em_lo_ff));
   assign req_ready = advance;

   // three-compare sort on y, strict so equal rows keep order
   always_comb begin
      tsf_pkg::vtx_type a, b, c, t;
      a = '{x: req_data.ax, y: req_data.ay};
      b = '{x: req_data.bx, y: req_data.by_coord};
      c = '{x: req_data.cx, y: req_data.cy};
      t = a;
      if (a.y > b.y) begin
         t = a; a = b; b = t;
      end
      if (b.y > c.y) begin
         t = b; b = c; c = t;
      end
      if (a.y > b.y) begin
         t = a; a = b; b = t;
      end
      ctx_in.a   = a;
      ctx_in.b   = b;
      ctx_in.c   = c;
      ctx_in.row = req_data.row;
      ctx_in.lvl = req_data.fill_level;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
         sl_vld_ff <= 1'b0;
         mu_vld_ff <= 1'b0;
         em_up_ff  <= 1'b0;
         em_lo_ff  <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 0; k < NS; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         sl_vld_ff <= vld_ff[NS];
         mu_vld_ff <= sl_vld_ff;
         em_up_ff  <= mu_vld_ff && mu_up_ff;
         em_lo_ff  <= mu_vld_ff && mu_lo_ff;
      end else if (rsp_ready) begin
         // both spans pending: upper one leaves first
         em_up_ff <= 1'b0;
      end
   end

   // sort result and divider setup, then the division steps
   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff[0]                   <= ctx_in;
         div_ff[0][tsf_pkg::EDGE_AB] <= tsf_pkg::div_init(ctx_in.a, ctx_in.b);
         div_ff[0][tsf_pkg::EDGE_AC] <= tsf_pkg::div_init(ctx_in.a, ctx_in.c);
         div_ff[0][tsf_pkg::EDGE_BC] <= tsf_pkg::div_init(ctx_in.b, ctx_in.c);
         for (int k = 0; k < NS; k++) begin
            ctx_ff[k+1] <= ctx_ff[k];
            for (int e = 0; e < NE; e++) begin
               div_ff[k+1][e] <= tsf_pkg::div_step(div_ff[k][e], k * tsf_pkg::STEP_BITS);
            end
         end
      end
   end

   // signed slopes, row offsets and row range tests
   always_ff @(posedge clock) begin
      if (advance) begin
         sl_ctx_ff <= ctx_ff[NS];
         for (int e = 0; e < NE; e++) begin
            sl_s_ff[e] <= tsf_pkg::div_slope(div_ff[NS][e]);
         end
         sl_offa_ff <= signed'({1'b0, ctx_ff[NS].row}) - signed'({1'b0, ctx_ff[NS].a.y});
         sl_offb_ff <= signed'({1'b0, ctx_ff[NS].row}) - signed'({1'b0, ctx_ff[NS].b.y});
         sl_up_ff   <= (ctx_ff[NS].row >= ctx_ff[NS].a.y) && (ctx_ff[NS].row <= ctx_ff[NS].b.y);
         sl_lo_ff   <= (ctx_ff[NS].row >= ctx_ff[NS].b.y) && (ctx_ff[NS].row <= ctx_ff[NS].c.y);
      end
   end

   // offset times slope
   always_ff @(posedge clock) begin
      if (advance) begin
         mu_ctx_ff                    <= sl_ctx_ff;
         mu_up_ff                     <= sl_up_ff;
         mu_lo_ff                     <= sl_lo_ff;
         mu_p_ff[tsf_pkg::EDGE_AB]    <= sl_offa_ff * sl_s_ff[tsf_pkg::EDGE_AB];
         mu_p_ff[tsf_pkg::EDGE_AC]    <= sl_offa_ff * sl_s_ff[tsf_pkg::EDGE_AC];
         mu_p_ff[tsf_pkg::EDGE_BC]    <= sl_offb_ff * sl_s_ff[tsf_pkg::EDGE_BC];
      end
   end

   // edge x positions
   assign x_ab = tsf_pkg::edge_x(mu_ctx_ff.a.x, mu_p_ff[tsf_pkg::EDGE_AB]);
   assign x_ac = tsf_pkg::edge_x(mu_ctx_ff.a.x, mu_p_ff[tsf_pkg::EDGE_AC]);
   assign x_bc = tsf_pkg::edge_x(mu_ctx_ff.b.x, mu_p_ff[tsf_pkg::EDGE_BC]);

   // ordered spans for both halves
   always_ff @(posedge clock) begin
      if (advance) begin
         em_hi_ff.span_row   <= mu_ctx_ff.row;
         em_hi_ff.span_start <= (x_ab < x_ac) ? x_ab : x_ac;
         em_hi_ff.span_end   <= (x_ab < x_ac) ? x_ac : x_ab;
         em_hi_ff.span_level <= mu_ctx_ff.lvl;
         em_hi_ff.last_span  <= !mu_lo_ff;
         em_lw_ff.span_row   <= mu_ctx_ff.row;
         em_lw_ff.span_start <= (x_bc < x_ac) ? x_bc : x_ac;
         em_lw_ff.span_end   <= (x_bc < x_ac) ? x_ac : x_bc;
         em_lw_ff.span_level <= mu_ctx_ff.lvl;
         em_lw_ff.last_span  <= 1'b1;
      end
   end

   // result word
   assign rsp_valid = em_up_ff || em_lo_ff;
   assign rsp_data  = em_up_ff ? em_hi_ff : em_lw_ff;

endmodule

@@ tb/tb.sv @@
module tb;

   localparam int LATENCY   = tsf_pkg::DIV_STAGES + 3;
   localparam int NUM_RAND  = 2000;
   localparam longint ONE_Q = longint'(1) << tsf_pkg::FRAC_BITS;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tsf_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tsf_pkg::rsp_type rsp_data;

   tsf_pkg::rsp_type span_queue[$];
   int      fail_count;
   bit      stim_done;

   triangle_scanline_fill dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // directed row: query plus hand-typed spans where obvious
   typedef struct {
      tsf_pkg::req_type q;
      int               n_spans;
      tsf_pkg::rsp_type s0;
      tsf_pkg::rsp_type s1;
      bit               typed;
   } row_entry_type;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // inverse slope, truncated toward zero, 0 for a flat edge
   function automatic longint inv_slope_q(longint px, longint py, longint qx, longint qy);
      longint dy;
      dy = qy - py;
      if (dy <= 0) begin
         return 0;
      end
      return ((qx - px) * ONE_Q) / dy;
   endfunction

   // floored edge x on a row, clamped
   function automatic longint edge_col(longint sx, longint sy, longint slope, longint r);
      longint v;
      longint f;
      v = sx * ONE_Q + (r - sy) * slope;
      if (v >= 0) begin
         f = v / ONE_Q;
      end else begin
         f = -((-v + ONE_Q - 1) / ONE_Q);
      end
      if (f < 0) begin
         f = 0;
      end
      if (f > 255) begin
         f = 255;
      end
      return f;
   endfunction

   function automatic tsf_pkg::rsp_type make_span(tsf_pkg::req_type q, longint xa,
                                                  longint xb);
      tsf_pkg::rsp_type s;
      s.span_row   = q.row;
      s.span_start = tsf_pkg::coord_type'(xa < xb ? xa : xb);
      s.span_end   = tsf_pkg::coord_type'(xa < xb ? xb : xa);
      s.span_level = q.fill_level;
      s.last_span  = 1'b0;
      return s;
   endfunction

   // work out the spans of one query and queue them
   task automatic predict_spans(tsf_pkg::req_type q);
      longint vx[3];
      longint vy[3];
      longint t;
      longint r;
      longint s_ab;
      longint s_ac;
      longint s_bc;
      tsf_pkg::rsp_type got[$];
      vx[0] = q.ax; vy[0] = q.ay;
      vx[1] = q.bx; vy[1] = q.by_coord;
      vx[2] = q.cx; vy[2] = q.cy;
      // strict bubble: (a,b), (b,c), (a,b)
      for (int k = 0; k < 3; k++) begin
         int i;
         i = (k == 1) ? 1 : 0;
         if (vy[i] > vy[i+1]) begin
            t = vy[i]; vy[i] = vy[i+1]; vy[i+1] = t;
            t = vx[i]; vx[i] = vx[i+1]; vx[i+1] = t;
         end
      end
      r    = q.row;
      s_ab = inv_slope_q(vx[0], vy[0], vx[1], vy[1]);
      s_ac = inv_slope_q(vx[0], vy[0], vx[2], vy[2]);
      s_bc = inv_slope_q(vx[1], vy[1], vx[2], vy[2]);
      if (r >= vy[0] && r <= vy[1]) begin
         got.push_back(make_span(q, edge_col(vx[0], vy[0], s_ab, r),
                                 edge_col(vx[0], vy[0], s_ac, r)));
      end
      if (r >= vy[1] && r <= vy[2]) begin
         got.push_back(make_span(q, edge_col(vx[1], vy[1], s_bc, r),
                                 edge_col(vx[0], vy[0], s_ac, r)));
      end
      if (got.size() > 0) begin
         got[got.size()-1].last_span = 1'b1;
      end
      foreach (got[i]) begin
         span_queue.push_back(got[i]);
      end
   endtask

   function automatic tsf_pkg::req_type make_query(int ax, int ay, int bx, int by, int cx,
                                                   int cy, int r, int lvl);
      tsf_pkg::req_type q;
      q.ax         = tsf_pkg::coord_type'(ax);
      q.ay         = tsf_pkg::coord_type'(ay);
      q.bx         = tsf_pkg::coord_type'(bx);
      q.by_coord   = tsf_pkg::coord_type'(by);
      q.cx         = tsf_pkg::coord_type'(cx);
      q.cy         = tsf_pkg::coord_type'(cy);
      q.row        = tsf_pkg::coord_type'(r);
      q.fill_level = tsf_pkg::LEVEL_BITS'(lvl);
      return q;
   endfunction

   // random query: mostly rows inside the triangle
   function automatic tsf_pkg::req_type random_query();
      tsf_pkg::req_type q;
      int      lo;
      int      hi;
      q = tsf_pkg::req_type'({$urandom, $urandom});
      case ($urandom_range(9))
         0: begin
            // small triangle near a corner
            q.ax       = tsf_pkg::coord_type'($urandom_range(15));
            q.ay       = tsf_pkg::coord_type'($urandom_range(15));
            q.bx       = tsf_pkg::coord_type'($urandom_range(15));
            q.by_coord = tsf_pkg::coord_type'($urandom_range(15));
            q.cx       = tsf_pkg::coord_type'($urandom_range(15));
            q.cy       = tsf_pkg::coord_type'($urandom_range(15));
            q.row      = tsf_pkg::coord_type'($urandom_range(15));
         end
         1: q.row = q.by_coord;
         2: q.row = q.ay;
         3: q.cy = q.ay;
         default: begin
         end
      endcase
      lo = q.ay; hi = q.ay;
      if (q.by_coord < lo) lo = q.by_coord;
      if (q.cy < lo) lo = q.cy;
      if (q.by_coord > hi) hi = q.by_coord;
      if (q.cy > hi) hi = q.cy;
      if ($urandom_range(9) < 7) begin
         q.row = tsf_pkg::coord_type'($urandom_range(hi, lo));
      end
      return q;
   endfunction

   // offer one word, held until accepted
   task automatic send_query(tsf_pkg::req_type q);
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_spans(q);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // stimulus
   initial begin
      row_entry_type dir[$];
      row_entry_type e;
      int            burst;
      req_valid  = 1'b0;
      req_data   = '0;
      reset      = 1'b1;
      stim_done  = 1'b0;
      fail_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // row above, below, typed
      e = '{default: '0};
      e.q = make_query(10, 50, 20, 60, 30, 70, 49, 8'hA5); e.typed = 1; dir.push_back(e);
      e.q = make_query(10, 50, 20, 60, 30, 70, 71, 8'h5A); dir.push_back(e);
      // flat triangle: upper half collapses on the first vertex, lower half spans a to b
      e.q = make_query(0, 128, 255, 128, 77, 128, 128, 8'hFF);
      e.n_spans = 2;
      e.s0 = '{span_row: 128, span_start: 0, span_end: 0, span_level: 8'hFF, last_span: 0};
      e.s1 = '{span_row: 128, span_start: 0, span_end: 255, span_level: 8'hFF,
               last_span: 1};
      dir.push_back(e);
      // degenerate point at the origin and at the far corner
      e.q = make_query(0, 0, 0, 0, 0, 0, 0, 0);
      e.s0 = '{span_row: 0, span_start: 0, span_end: 0, span_level: 0, last_span: 0};
      e.s1 = '{span_row: 0, span_start: 0, span_end: 0, span_level: 0, last_span: 1};
      dir.push_back(e);
      e.q = make_query(255, 255, 255, 255, 255, 255, 255, 255);
      e.s0 = '{span_row: 255, span_start: 255, span_end: 255, span_level: 255,
               last_span: 0};
      e.s1 = '{span_row: 255, span_start: 255, span_end: 255, span_level: 255,
               last_span: 1};
      dir.push_back(e);
      e.typed = 0;
      // predicted rows: every sort order but c < a < b, ties, steep and shallow edges
      dir.push_back('{q: make_query(0, 0, 255, 128, 0, 255, 128, 1), default: '0});
      dir.push_back('{q: make_query(0, 255, 255, 128, 0, 0, 64, 2), default: '0});
      dir.push_back('{q: make_query(255, 128, 0, 0, 128, 255, 200, 3), default: '0});
      dir.push_back('{q: make_query(255, 0, 0, 255, 0, 0, 0, 4), default: '0});
      dir.push_back('{q: make_query(7, 9, 200, 9, 100, 250, 9, 5), default: '0});
      dir.push_back('{q: make_query(7, 9, 200, 250, 100, 250, 250, 6), default: '0});
      dir.push_back('{q: make_query(3, 0, 250, 1, 128, 255, 254, 7), default: '0});
      dir.push_back('{q: make_query(0, 0, 255, 3, 1, 255, 2, 8), default: '0});
      dir.push_back('{q: make_query(255, 0, 0, 3, 254, 255, 1, 9), default: '0});
      dir.push_back('{q: make_query(100, 10, 50, 200, 150, 100, 100, 10), default: '0});
      dir.push_back('{q: make_query(100, 10, 50, 200, 150, 100, 150, 11), default: '0});
      dir.push_back('{q: make_query(1, 2, 254, 253, 128, 127, 127, 12), default: '0});
      dir.push_back('{q: make_query(0, 255, 255, 0, 128, 128, 255, 13), default: '0});

      foreach (dir[i]) begin
         if (dir[i].typed) begin
            // typed expectations, predictor bypassed
            req_valid <= 1'b1;
            req_data  <= dir[i].q;
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            if (dir[i].n_spans > 0) span_queue.push_back(dir[i].s0);
            if (dir[i].n_spans > 1) span_queue.push_back(dir[i].s1);
            @(negedge clock);
         end else begin
            send_query(dir[i].q);
         end
      end

      // random part in bursts
      for (int n = 0; n < NUM_RAND; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < NUM_RAND; k++, n++) begin
            send_query(random_query());
         end
         if ($urandom_range(3) != 0) idle_gap();
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (300) begin
         @(negedge clock);
         rsp_ready <= 1'b1;
      end
      rsp_ready <= 1'b0;
      repeat (200) @(negedge clock);
      forever begin
         mode = $urandom_range(3);
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(3) != 0);
               2: rsp_ready <= 1'($urandom_range(1));
               default: rsp_ready <= ($urandom_range(4) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // compare each accepted word with the oldest span expected
   always @(posedge clock) begin
      tsf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (span_queue.size() == 0) begin
            $error("unexpected span word: %p", rsp_data);
            fail_count++;
         end else begin
            want = span_queue.pop_front();
            if (rsp_data.span_row !== want.span_row) begin
               $error("span_row expected %0d actual %0d", want.span_row, rsp_data.span_row);
               fail_count++;
            end
            if (rsp_data.span_start !== want.span_start) begin
               $error("span_start expected %0d actual %0d", want.span_start,
                      rsp_data.span_start);
               fail_count++;
            end
            if (rsp_data.span_end !== want.span_end) begin
               $error("span_end expected %0d actual %0d", want.span_end, rsp_data.span_end);
               fail_count++;
            end
            if (rsp_data.span_level !== want.span_level) begin
               $error("span_level expected %0d actual %0d", want.span_level,
                      rsp_data.span_level);
               fail_count++;
            end
            if (rsp_data.last_span !== want.last_span) begin
               $error("last_span expected %0d actual %0d", want.last_span,
                      rsp_data.last_span);
               fail_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      @(posedge clock);
      wait (stim_done);
      while (span_queue.size() != 0) @(posedge clock);
      repeat (4 * LATENCY + 20) @(posedge clock);
      if (span_queue.size() == 0 && fail_count == 0) begin
         $display("triangle_scanline_fill regression: pass");
      end else begin
         $display("triangle_scanline_fill regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("triangle_scanline_fill regression: fail");
      $finish;
   end

endmodule
